// ===== sv/eas_pkg.sv =====
// Package for the encoder angle and speed estimator.
// Holds field widths, scale constants, operation codes and the command struct.
// No dependencies.
package eas_pkg;

  localparam int ANGLE_W     = 12;
  localparam int TIME_W      = 32;
  localparam int ANGLE_OUT_W = 18;
  localparam int SPEED_W     = 24;
  localparam int STEP_W      = 13;
  localparam int QUO_W       = 23;
  localparam int CNT_W       = 5;

  localparam logic [CNT_W-1:0]   DIV_LAST    = CNT_W'(QUO_W - 1);
  localparam logic [STEP_W-1:0]  HALF_TURN   = STEP_W'(2048);
  localparam logic [STEP_W-1:0]  FULL_TURN   = STEP_W'(4096);
  localparam logic [SPEED_W-1:0] SPEED_SCALE = SPEED_W'(3750);
  localparam logic [ANGLE_OUT_W-1:0] ANGLE_SCALE = ANGLE_OUT_W'(45);

  localparam logic OP_PRIME   = 1'b0;
  localparam logic OP_MEASURE = 1'b1;

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic wb;
  } cmd_t;

endpackage

// ===== sv/eas_in_if.sv =====
// Input channel of the encoder angle and speed estimator.
// Carries valid, ready and one sample transaction; depends on eas_pkg.
interface eas_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [eas_pkg::ANGLE_W-1:0] raw_angle;
  logic [eas_pkg::TIME_W-1:0]  time_ms;

  modport source (output valid, output operation, output raw_angle, output time_ms,
                  input ready);
  modport sink (input valid, input operation, input raw_angle, input time_ms,
                output ready);
endinterface

// ===== sv/eas_out_if.sv =====
// Result channel of the encoder angle and speed estimator.
// Carries valid, ready and one result transaction; depends on eas_pkg.
interface eas_out_if;
  logic                               valid;
  logic                               ready;
  logic [eas_pkg::ANGLE_OUT_W-1:0]    angle_deg_q9;
  logic signed [eas_pkg::SPEED_W-1:0] speed_rpm_q8;

  modport source (output valid, output angle_deg_q9, output speed_rpm_q8, input ready);
  modport sink (input valid, input angle_deg_q9, input speed_rpm_q8, output ready);
endinterface

// ===== sv/eas_ctrl.sv =====
// Controller of the encoder angle and speed estimator.
// Sequences accept, multiply, divide and write-back; depends on eas_pkg.
module eas_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_op_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output eas_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_WB
  } state_e;

  state_e                     state_q, state_d;
  logic [eas_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                       out_valid_q, out_valid_d;
  logic                       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_op_i == eas_pkg::OP_MEASURE) begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == eas_pkg::DIV_LAST) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        if (out_free) begin
          cmd_o.wb    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== sv/eas_dp.sv =====
// Datapath of the encoder angle and speed estimator.
// Baseline registers, step and interval, scale multiply, restoring divider and
// result registers; depends on eas_pkg.
module eas_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  eas_pkg::cmd_t                      cmd_i,
  input  logic [eas_pkg::ANGLE_W-1:0]        raw_angle_i,
  input  logic [eas_pkg::TIME_W-1:0]         time_ms_i,
  output logic [eas_pkg::ANGLE_OUT_W-1:0]    angle_deg_q9_o,
  output logic signed [eas_pkg::SPEED_W-1:0] speed_rpm_q8_o
);

  logic [eas_pkg::ANGLE_W-1:0]     last_angle_q;
  logic [eas_pkg::TIME_W-1:0]      last_time_q;
  logic                            no_baseline_q;
  logic [eas_pkg::ANGLE_W-1:0]     cur_angle_q;
  logic [eas_pkg::ANGLE_W-1:0]     mag_q;
  logic                            neg_q;
  logic                            zero_q;
  logic [eas_pkg::TIME_W-1:0]      dt_q;
  logic [eas_pkg::QUO_W-1:0]       quo_q;
  logic [eas_pkg::TIME_W-1:0]      rem_q;
  logic [eas_pkg::ANGLE_OUT_W-1:0] angle_q;
  logic [eas_pkg::SPEED_W-1:0]     speed_q;

  logic [eas_pkg::STEP_W-1:0]      diff;
  logic [eas_pkg::STEP_W-1:0]      step;
  logic [eas_pkg::STEP_W-1:0]      step_abs;
  logic [eas_pkg::SPEED_W-1:0]     prod;
  logic [eas_pkg::TIME_W:0]        shifted;
  logic [eas_pkg::TIME_W+1:0]      trial;
  logic                            ge;
  logic [eas_pkg::SPEED_W-1:0]     quo_ext;

  always_comb begin
    diff = {1'b0, raw_angle_i} - {1'b0, last_angle_q};
    step = diff;
    if (!diff[eas_pkg::STEP_W-1] && diff > eas_pkg::HALF_TURN) begin
      step = diff - eas_pkg::FULL_TURN;
    end else if (diff[eas_pkg::STEP_W-1] && (-diff) > eas_pkg::HALF_TURN) begin
      step = diff + eas_pkg::FULL_TURN;
    end
    step_abs = step[eas_pkg::STEP_W-1] ? -step : step;
  end

  assign prod    = eas_pkg::SPEED_W'(mag_q) * eas_pkg::SPEED_SCALE;
  assign shifted = {rem_q, quo_q[eas_pkg::QUO_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dt_q};
  assign ge      = !trial[eas_pkg::TIME_W+1];
  assign quo_ext = eas_pkg::SPEED_W'(quo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_angle_q  <= '0;
      last_time_q   <= '0;
      no_baseline_q <= 1'b1;
    end else if (cmd_i.load) begin
      last_angle_q  <= raw_angle_i;
      last_time_q   <= time_ms_i;
      no_baseline_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_angle_q <= raw_angle_i;
      mag_q       <= step_abs[eas_pkg::ANGLE_W-1:0];
      neg_q       <= step[eas_pkg::STEP_W-1];
      zero_q      <= no_baseline_q || (time_ms_i == last_time_q);
      dt_q        <= time_ms_i - last_time_q;
    end
    if (cmd_i.mul) begin
      quo_q <= prod[eas_pkg::QUO_W-1:0];
      rem_q <= '0;
    end else if (cmd_i.step) begin
      quo_q <= {quo_q[eas_pkg::QUO_W-2:0], ge};
      rem_q <= ge ? trial[eas_pkg::TIME_W-1:0] : shifted[eas_pkg::TIME_W-1:0];
    end
    if (cmd_i.wb) begin
      angle_q <= eas_pkg::ANGLE_OUT_W'(cur_angle_q) * eas_pkg::ANGLE_SCALE;
      if (zero_q) begin
        speed_q <= '0;
      end else if (neg_q) begin
        speed_q <= -quo_ext;
      end else begin
        speed_q <= quo_ext;
      end
    end
  end

  assign angle_deg_q9_o = angle_q;
  assign speed_rpm_q8_o = $signed(speed_q);

endmodule

// ===== sv/encoder_angle_speed_estimator.sv =====
// Top level of the encoder angle and speed estimator.
// Joins eas_ctrl and eas_dp; depends on eas_pkg, eas_in_if and eas_out_if.
//
//   Port    Dir  Fields                                  Transaction
//   in_i    in   operation, raw_angle, time_ms           one sample
//   out_o   out  angle_deg_q9, speed_rpm_q8              one result per measure
//
// A prime transaction only updates the baseline; a measure transaction goes through
// accept, scale multiply, 23 steps of the restoring divider and write-back.
// One sample is in work at a time.
// Reset sets the baseline to angle 0, time 0, with no baseline held.
// A result waits in the output register while the next sample is taken in;
// write-back stalls only while that register is still full.
module encoder_angle_speed_estimator (
  input  logic       clk_i,
  input  logic       rst_ni,
  eas_in_if.sink     in_i,
  eas_out_if.source  out_o
);

  eas_pkg::cmd_t cmd;

  eas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_i.operation),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  eas_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .raw_angle_i    (in_i.raw_angle),
    .time_ms_i      (in_i.time_ms),
    .angle_deg_q9_o (out_o.angle_deg_q9),
    .speed_rpm_q8_o (out_o.speed_rpm_q8)
  );

endmodule

// ===== test/encoder_angle_speed_estimator_tb.sv =====
// Self-checking testbench for encoder_angle_speed_estimator: a directed table, then random samples.
// Each result is checked against an angle and speed predictor, or a typed reading from the table.
// Depends on eas_pkg, eas_in_if, eas_out_if and the top level of the block.
module encoder_angle_speed_estimator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import eas_pkg::*;

  typedef struct packed {
    logic [ANGLE_OUT_W-1:0]    angle;
    logic signed [SPEED_W-1:0] speed;
  } reading_t;

  typedef struct packed {
    logic               op;
    logic [ANGLE_W-1:0] raw;
    logic [TIME_W-1:0]  stamp;
    logic               typed;
    reading_t           reading;
  } sample_row_t;

  localparam int DIRECTED_ROWS = 19;
  localparam sample_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{OP_MEASURE, 12'd4095, 32'd100,         1'b1, '{18'd184275, 24'sd0}},
    '{OP_MEASURE, 12'd0,    32'd100,         1'b1, '{18'd0, 24'sd0}},
    '{OP_PRIME,   12'd0,    32'd0,           1'b0, '{18'd0, 24'sd0}},
    '{OP_MEASURE, 12'd2048, 32'd1,           1'b1, '{18'd92160, 24'sd7680000}},
    '{OP_MEASURE, 12'd0,    32'd2,           1'b1, '{18'd0, -24'sd7680000}},
    '{OP_MEASURE, 12'd2049, 32'd3,           1'b0, '{18'd0, 24'sd0}},
    '{OP_MEASURE, 12'd0,    32'd4,           1'b0, '{18'd0, 24'sd0}},
    '{OP_MEASURE, 12'd4095, 32'd5,           1'b0, '{18'd0, 24'sd0}},
    '{OP_MEASURE, 12'd0,    32'd6,           1'b0, '{18'd0, 24'sd0}},
    '{OP_PRIME,   12'd100,  32'hFFFF_FFFF,   1'b0, '{18'd0, 24'sd0}},
    '{OP_MEASURE, 12'd101,  32'd0,           1'b0, '{18'd0, 24'sd0}},
    '{OP_MEASURE, 12'd101,  32'hFFFF_FFFF,   1'b1, '{18'd4545, 24'sd0}},
    '{OP_MEASURE, 12'd4095, 32'h7FFF_FFFE,   1'b0, '{18'd0, 24'sd0}},
    '{OP_MEASURE, 12'd4000, 32'h8000_0005,   1'b0, '{18'd0, 24'sd0}},
    '{OP_MEASURE, 12'd4010, 32'h8000_0008,   1'b0, '{18'd0, 24'sd0}},
    '{OP_PRIME,   12'd2048, 32'd1000,        1'b0, '{18'd0, 24'sd0}},
    '{OP_PRIME,   12'd2000, 32'd1000,        1'b0, '{18'd0, 24'sd0}},
    '{OP_MEASURE, 12'd2000, 32'd1000,        1'b1, '{18'd90000, 24'sd0}},
    '{OP_MEASURE, 12'd1,    32'd1001,        1'b0, '{18'd0, 24'sd0}}
  };

  localparam int RANDOM_SAMPLES = 550;
  localparam int PHASE_LEN      = 50;
  localparam int DRAIN_CYCLES   = 40;

  logic clk;
  logic rst_n;

  eas_in_if  in_if ();
  eas_out_if out_if ();

  encoder_angle_speed_estimator dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic [ANGLE_W-1:0] base_angle;
  logic [TIME_W-1:0]  base_time;
  logic               no_baseline;

  reading_t pending_readings [$];
  int       fails;
  bit       src_idles;
  bit       sink_stalls;
  int       sink_hold;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #3ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic bit predict_reading(input logic op, input logic [ANGLE_W-1:0] raw,
                                         input logic [TIME_W-1:0] stamp,
                                         output reading_t reading);
    int                now_a;
    int                prev_a;
    int                step;
    logic [TIME_W-1:0] dt;
    longint            dt_l;
    longint            quo;
    now_a = raw;
    prev_a = base_angle;
    dt = stamp - base_time;
    dt_l = dt;
    quo = 0;
    reading = '0;
    if (op == OP_PRIME) begin
      base_angle = raw;
      base_time = stamp;
      no_baseline = 1'b0;
      return 1'b0;
    end
    if (no_baseline) begin
      no_baseline = 1'b0;
    end else if (dt != '0) begin
      step = now_a - prev_a;
      if (step > 2048) step -= 4096;
      if (step < -2048) step += 4096;
      quo = (longint'(step) * 3750) / dt_l;
    end
    base_angle = raw;
    base_time = stamp;
    reading.angle = ANGLE_OUT_W'(now_a * 45);
    reading.speed = quo[SPEED_W-1:0];
    return 1'b1;
  endfunction

  task automatic send_sample(input logic op, input logic [ANGLE_W-1:0] raw,
                             input logic [TIME_W-1:0] stamp, input logic typed,
                             input reading_t typed_reading);
    int       gap;
    reading_t predicted;
    gap = src_idles ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.raw_angle <= raw;
    in_if.time_ms   <= stamp;
    do @(posedge clk); while (!in_if.ready);
    if (predict_reading(op, raw, stamp, predicted))
      pending_readings.push_back(typed ? typed_reading : predicted);
  endtask

  always @(posedge clk) begin
    reading_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (pending_readings.size() == 0) begin
          $error("unexpected result: angle_deg_q9=%0d speed_rpm_q8=%0d",
                 out_if.angle_deg_q9, out_if.speed_rpm_q8);
          fails++;
        end else begin
          want = pending_readings.pop_front();
          if (out_if.angle_deg_q9 !== want.angle) begin
            $error("angle_deg_q9: expected %0d, got %0d", want.angle, out_if.angle_deg_q9);
            fails++;
          end
          if (out_if.speed_rpm_q8 !== want.speed) begin
            $error("speed_rpm_q8: expected %0d, got %0d", want.speed, out_if.speed_rpm_q8);
            fails++;
          end
        end
        sink_hold = sink_stalls ? $urandom_range(0, 13) : 0;
        out_if.ready <= (sink_hold == 0);
      end else if (sink_hold > 0) begin
        sink_hold--;
        if (sink_hold == 0) out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [ANGLE_W-1:0] raw;
    logic [TIME_W-1:0]  stamp;
    logic               op;
    fails = 0;
    sink_hold = 0;
    src_idles = 1'b1;
    sink_stalls = 1'b1;
    base_angle = '0;
    base_time = '0;
    no_baseline = 1'b1;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.operation = OP_PRIME;
    in_if.raw_angle = '0;
    in_if.time_ms = '0;
    out_if.ready = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i])
      send_sample(DIRECTED[i].op, DIRECTED[i].raw, DIRECTED[i].stamp, DIRECTED[i].typed,
                  DIRECTED[i].reading);

    for (int n = 0; n < RANDOM_SAMPLES; n++) begin
      if (n % PHASE_LEN == 0) begin
        src_idles = ((n / PHASE_LEN) % 4) inside {0, 2};
        sink_stalls = ((n / PHASE_LEN) % 4) inside {0, 3};
      end
      op = ($urandom_range(0, 9) == 0) ? OP_PRIME : OP_MEASURE;
      case ($urandom_range(0, 5))
        0:       raw = ANGLE_W'($urandom);
        1, 2:    raw = base_angle + ANGLE_W'($urandom_range(0, 64)) - 12'd32;
        3:       raw = base_angle + 12'd2048 + ANGLE_W'($urandom_range(0, 4)) - 12'd2;
        default: raw = base_angle + ANGLE_W'($urandom_range(0, 600)) - 12'd300;
      endcase
      case ($urandom_range(0, 7))
        0:       stamp = base_time;
        1:       stamp = $urandom;
        2:       stamp = base_time - TIME_W'($urandom_range(1, 5));
        default: stamp = base_time + TIME_W'($urandom_range(1, 40));
      endcase
      send_sample(op, raw, stamp, 1'b0, '0);
    end
    in_if.valid <= 1'b0;

    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
